// File: src/qlsf_pkg.sv
// ----------------------------------------------------------------------------
// qlsf_pkg
// Types and constants shared by the quadratic least-squares fit block.
// ----------------------------------------------------------------------------
package qlsf_pkg;

    localparam int X_W         = 12;
    localparam int Y_W         = 16;
    localparam int COEF_W      = 64;
    localparam int STAT_W      = 2;
    localparam int MAX_POINTS  = 1024;
    localparam int FRAC_BITS   = 32;
    localparam int CNT_W       = 11;
    localparam int SX_W        = 23;
    localparam int SX2_W       = 33;
    localparam int SX3_W       = 45;
    localparam int SX4_W       = 55;
    localparam int SY_W        = 27;
    localparam int SXY_W       = 38;
    localparam int SX2Y_W      = 49;
    localparam int ELEM_W      = 64;
    localparam int BIT_CNT_W   = $clog2(ELEM_W);
    localparam int DET_W       = 128;
    localparam int DIV_W       = DET_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int TERMS       = 6;
    localparam int TERM_W      = 3;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [X_W-1:0] x_value;
        logic signed [Y_W-1:0] y_value;
        logic                  last_point;
    } in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coeff_quad;
        logic signed [COEF_W-1:0] coeff_lin;
        logic signed [COEF_W-1:0] coeff_const;
        logic [STAT_W-1:0]        fit_status;
    } out_t;

    typedef struct packed {
        logic [CNT_W-1:0]         point_count;
        logic                     count_overflow;
        logic signed [SX_W-1:0]   sum_x;
        logic signed [SX2_W-1:0]  sum_x_sq;
        logic signed [SX3_W-1:0]  sum_x_cube;
        logic signed [SX4_W-1:0]  sum_x_fourth;
        logic signed [SY_W-1:0]   sum_y;
        logic signed [SXY_W-1:0]  sum_xy;
        logic signed [SX2Y_W-1:0] sum_x_sq_y;
    } sums_t;

endpackage

// File: src/qlsf_front.sv
// ----------------------------------------------------------------------------
// qlsf_front
// Point intake: power pipeline and running sums, one point per cycle while not stalled.
// ----------------------------------------------------------------------------
module qlsf_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qlsf_pkg::in_t   in_data,
    output logic            push,
    output qlsf_pkg::sums_t push_data,
    input  logic            full
);
    import qlsf_pkg::*;

    localparam int X2_W  = 24;
    localparam int XY_W  = 28;
    localparam int X3_W  = 35;
    localparam int X4_W  = 47;
    localparam int X2Y_W = 40;

    logic                    en;
    logic                    a_valid_reg, b_valid_reg, c_valid_reg;
    logic                    a_last_reg, b_last_reg, c_last_reg;
    logic signed [X_W-1:0]   a_x_reg, b_x_reg, c_x_reg;
    logic signed [Y_W-1:0]   a_y_reg, b_y_reg, c_y_reg;
    logic signed [X2_W-1:0]  b_x2_reg, c_x2_reg;
    logic signed [XY_W-1:0]  b_xy_reg, c_xy_reg;
    logic signed [X3_W-1:0]  c_x3_reg;
    logic signed [X4_W-1:0]  c_x4_reg;
    logic signed [X2Y_W-1:0] c_x2y_reg;
    sums_t                   sums_reg, sums_next, sums_add;

    assign en       = !(c_valid_reg && c_last_reg && full);
    assign in_ready = en;

    always_comb
    begin
        sums_add = sums_reg;
        if (c_valid_reg)
        begin
            if (sums_reg.point_count < CNT_W'(MAX_POINTS))
            begin
                sums_add.point_count  = sums_reg.point_count + CNT_W'(1);
                sums_add.sum_x        = sums_reg.sum_x + SX_W'(c_x_reg);
                sums_add.sum_x_sq     = sums_reg.sum_x_sq + SX2_W'(c_x2_reg);
                sums_add.sum_x_cube   = sums_reg.sum_x_cube + SX3_W'(c_x3_reg);
                sums_add.sum_x_fourth = sums_reg.sum_x_fourth + SX4_W'(c_x4_reg);
                sums_add.sum_y        = sums_reg.sum_y + SY_W'(c_y_reg);
                sums_add.sum_xy       = sums_reg.sum_xy + SXY_W'(c_xy_reg);
                sums_add.sum_x_sq_y   = sums_reg.sum_x_sq_y + SX2Y_W'(c_x2y_reg);
            end
            else
            begin
                sums_add.count_overflow = 1'b1;
            end
        end
        push      = c_valid_reg && c_last_reg && en;
        push_data = sums_add;
        if (!en)
            sums_next = sums_reg;
        else if (push)
            sums_next = '0;
        else
            sums_next = sums_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            sums_reg    <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
            if (en)
            begin
                a_valid_reg <= in_valid;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg    <= in_data.x_value;
            a_y_reg    <= in_data.y_value;
            a_last_reg <= in_data.last_point;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_last_reg <= a_last_reg;
            b_x2_reg   <= a_x_reg * a_x_reg;
            b_xy_reg   <= a_x_reg * a_y_reg;
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
            c_last_reg <= b_last_reg;
            c_x2_reg   <= b_x2_reg;
            c_xy_reg   <= b_xy_reg;
            c_x3_reg   <= b_x2_reg * b_x_reg;
            c_x4_reg   <= b_x2_reg * b_x2_reg;
            c_x2y_reg  <= b_x2_reg * b_y_reg;
        end
    end

endmodule

// File: src/qlsf_queue.sv
// ----------------------------------------------------------------------------
// qlsf_queue
// Short queue of finished sum sets between intake and solver.
// ----------------------------------------------------------------------------
module qlsf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qlsf_pkg::sums_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output qlsf_pkg::sums_t pop_data
);
    import qlsf_pkg::*;

    sums_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && pop_valid))
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!push && pop && pop_valid)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop && pop_valid)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/qlsf_div.sv
// ----------------------------------------------------------------------------
// qlsf_div
// Restoring divider: saturated fixed-point quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module qlsf_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [qlsf_pkg::DET_W-1:0]   num,
    input  logic [qlsf_pkg::DET_W-1:0]   den,
    output logic                         done,
    output logic [qlsf_pkg::COEF_W-1:0]  quot
);
    import qlsf_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic                 neg_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DET_W-1:0]     dvs_reg, rem_reg;
    logic [DET_W-1:0]     num_abs, den_abs;
    logic [DET_W:0]       rem_sh, diff;
    logic                 ge;
    logic                 hi;
    logic [COEF_W-1:0]    mag, min_val, max_val;

    assign num_abs = num[DET_W-1] ? (~num + DET_W'(1)) : num;
    assign den_abs = den[DET_W-1] ? (~den + DET_W'(1)) : den;
    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff    = rem_sh - {1'b0, dvs_reg};
    assign ge      = (rem_sh >= {1'b0, dvs_reg});

    assign hi      = |dvd_reg[DIV_W-1:COEF_W];
    assign mag     = dvd_reg[COEF_W-1:0];
    assign min_val = COEF_W'(1) << (COEF_W - 1);
    assign max_val = ~min_val;
    assign done    = done_reg;

    always_comb
    begin
        if (neg_reg)
            quot = (hi || mag > min_val) ? min_val : (~mag + COEF_W'(1));
        else
            quot = (hi || mag > max_val) ? max_val : mag;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
            cnt_next = DIV_CNT_W'(DIV_W);
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[DET_W-1] ^ den[DET_W-1];
            dvd_reg <= DIV_W'(num_abs) << FRAC_BITS;
            dvs_reg <= den_abs;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DET_W-1:0] : rem_sh[DET_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
        end
    end

endmodule

// File: src/qlsf_solve.sv
// ----------------------------------------------------------------------------
// qlsf_solve
// Cramer's rule solver: serial shift-add products, divider, result register.
// ----------------------------------------------------------------------------
module qlsf_solve
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  qlsf_pkg::sums_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output qlsf_pkg::out_t  out_data
);
    import qlsf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_MUL2 = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    // coefficient matrix entry, with column k-1 swapped for the right-hand side
    function automatic logic signed [ELEM_W-1:0] elem(input sums_t s, input logic [1:0] k,
                                                      input logic [1:0] r, input logic [1:0] c);
        logic [2:0] rc;
        logic signed [ELEM_W-1:0] v;
        rc = {1'b0, r} + {1'b0, c};
        if (k != 2'd0 && c == k - 2'd1)
        begin
            case (r)
                2'd0:    v = ELEM_W'(s.sum_x_sq_y);
                2'd1:    v = ELEM_W'(s.sum_xy);
                default: v = ELEM_W'(s.sum_y);
            endcase
        end
        else
        begin
            case (rc)
                3'd0:    v = ELEM_W'(s.sum_x_fourth);
                3'd1:    v = ELEM_W'(s.sum_x_cube);
                3'd2:    v = ELEM_W'(s.sum_x_sq);
                3'd3:    v = ELEM_W'(s.sum_x);
                default: v = $signed(ELEM_W'(s.point_count));
            endcase
        end
        return v;
    endfunction

    // {negate, column of row 0, row 1, row 2}
    function automatic logic [6:0] perm(input logic [TERM_W-1:0] t);
        logic [6:0] p;
        case (t)
            3'd0:    p = {1'b0, 2'd0, 2'd1, 2'd2};
            3'd1:    p = {1'b1, 2'd0, 2'd2, 2'd1};
            3'd2:    p = {1'b1, 2'd1, 2'd0, 2'd2};
            3'd3:    p = {1'b0, 2'd1, 2'd2, 2'd0};
            3'd4:    p = {1'b0, 2'd2, 2'd0, 2'd1};
            default: p = {1'b1, 2'd2, 2'd1, 2'd0};
        endcase
        return p;
    endfunction

    state_t                   state_reg, state_next;
    sums_t                    sums_reg, sums_next;
    out_t                     out_reg, out_next;
    logic [1:0]               k_reg, k_next;
    logic [TERM_W-1:0]        t_reg, t_next;
    logic [BIT_CNT_W-1:0]     bit_reg, bit_next;
    logic [DET_W-1:0]         ma_reg, ma_next, prod_reg, prod_next;
    logic [ELEM_W-1:0]        mb_reg, mb_next;
    logic [DET_W-1:0]         acc_reg, acc_next, det_reg, det_next;
    logic [DET_W-1:0]         prod_step;
    logic                     bit_last;
    logic [6:0]               pm;
    logic signed [ELEM_W-1:0] e0, e1, e2;
    logic                     div_start, div_done;
    logic [COEF_W-1:0]        div_quot;

    assign pm        = perm(t_reg);
    assign e0        = elem(sums_reg, k_reg, 2'd0, pm[5:4]);
    assign e1        = elem(sums_reg, k_reg, 2'd1, pm[3:2]);
    assign e2        = elem(sums_reg, k_reg, 2'd2, pm[1:0]);
    assign bit_last  = (bit_reg == BIT_CNT_W'(ELEM_W - 1));
    assign prod_step = !mb_reg[0] ? prod_reg :
                       (bit_last ? prod_reg - ma_reg : prod_reg + ma_reg);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    qlsf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (det_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        sums_next  = sums_reg;
        out_next   = out_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        bit_next   = bit_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        det_next   = det_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    sums_next = q_data;
                    out_next  = '0;
                    k_next    = 2'd0;
                    t_next    = '0;
                    acc_next  = '0;
                    if (q_data.count_overflow)
                    begin
                        out_next.fit_status = ST_OVERFLOW;
                        state_next          = S_OUT;
                    end
                    else
                        state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                ma_next    = DET_W'(e0);
                mb_next    = e1;
                prod_next  = '0;
                bit_next   = '0;
                state_next = S_MUL1;
            end
            S_MUL1, S_MUL2:
            begin
                prod_next = prod_step;
                ma_next   = ma_reg << 1;
                mb_next   = mb_reg >> 1;
                bit_next  = bit_reg + BIT_CNT_W'(1);
                if (bit_last && state_reg == S_MUL1)
                begin
                    ma_next    = prod_step;
                    mb_next    = e2;
                    prod_next  = '0;
                    bit_next   = '0;
                    state_next = S_MUL2;
                end
                else if (bit_last)
                begin
                    acc_next = pm[6] ? acc_reg - prod_step : acc_reg + prod_step;
                    if (t_reg == TERM_W'(TERMS - 1))
                        state_next = S_FIN;
                    else
                    begin
                        t_next     = t_reg + TERM_W'(1);
                        state_next = S_LOAD;
                    end
                end
            end
            S_FIN:
            begin
                if (k_reg == 2'd0)
                begin
                    det_next = acc_reg;
                    if (acc_reg == '0)
                    begin
                        out_next.fit_status = ST_SINGULAR;
                        state_next          = S_OUT;
                    end
                    else
                    begin
                        k_next     = 2'd1;
                        t_next     = '0;
                        acc_next   = '0;
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    unique case (k_reg)
                        2'd1:    out_next.coeff_quad  = div_quot;
                        2'd2:    out_next.coeff_lin   = div_quot;
                        default: out_next.coeff_const = div_quot;
                    endcase
                    if (k_reg == 2'd3)
                    begin
                        out_next.fit_status = ST_OK;
                        state_next          = S_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        t_next     = '0;
                        acc_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            t_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            t_reg     <= t_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sums_reg <= sums_next;
        out_reg  <= out_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        det_reg  <= det_next;
    end

endmodule

// File: src/quadratic_least_squares_fit.sv
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Least-squares fit y = a*x^2 + b*x + c over sets of integer points.
// ----------------------------------------------------------------------------
// Points are taken one per cycle through a three-stage power pipeline into
// running sums. The point marked last closes the set: its sums go to a
// two-entry queue and the sums clear. A solver then works each set alone:
// four 3x3 determinants, each of six triple products formed on a 64-bit
// shift-add multiplier, then three 160-step restoring divisions; singular
// and overflowed sets finish early. Point intake stalls only when a set
// closes while two finished sets still wait in the queue.
module quadratic_least_squares_fit
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qlsf_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qlsf_pkg::out_t out_data
);
    import qlsf_pkg::*;

    logic  push, full, pop, pop_valid;
    sums_t push_data, pop_data;

    qlsf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    qlsf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    qlsf_solve u_solve
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("set pushed into full queue");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> full)
        else $error("intake stalled with queue space");

    a_zero_coeffs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fit_status != ST_OK |->
        out_data.coeff_quad == '0 && out_data.coeff_lin == '0 &&
        out_data.coeff_const == '0)
        else $error("nonzero coefficients on failed fit");

endmodule

// File: sim/tb_quadratic_least_squares_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_least_squares_fit
// Self-checking bench for the quadratic least-squares fit block.
// ----------------------------------------------------------------------------
// A short directed table of extremes, exact fits and singular sets and a
// run past the point limit precede random point sets. Every accepted point
// updates a local set of sums. A closing point gives an expected coefficient
// set, which comes from exact wide-integer Cramer's rule. Both handshakes see
// random gaps. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_quadratic_least_squares_fit;

    import qlsf_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [319:0] quot_t;

    typedef struct {
        in_t  pt;
        bit   typed;
        out_t fit;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    longint n_pts, s_x, s_x2, s_x3, s_x4, s_y, s_xy, s_x2y;
    bit     pts_dropped;
    out_t   fit_q[$];
    int     errors;
    bit     sending_done;
    row_t   dir_rows[$];

    quadratic_least_squares_fit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #1_000_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic wide_t det3(wide_t a, wide_t b, wide_t c, wide_t d, wide_t e,
                                   wide_t f, wide_t g, wide_t h, wide_t i);
        return a*e*i - a*f*h - b*d*i + b*f*g + c*d*h - c*e*g;
    endfunction

    function automatic logic signed [63:0] q32_div(wide_t num, wide_t den);
        quot_t n;
        quot_t q;
        quot_t q_max;
        n     = quot_t'(num);
        n     = n <<< FRAC_BITS;
        q     = n / quot_t'(den);
        q_max = $signed(320'h7FFF_FFFF_FFFF_FFFF);
        if (q > q_max)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (q < -q_max - 1)
            return 64'sh8000_0000_0000_0000;
        return q[63:0];
    endfunction

    function automatic void clear_sums();
        n_pts = 0; s_x = 0; s_x2 = 0; s_x3 = 0; s_x4 = 0;
        s_y = 0; s_xy = 0; s_x2y = 0; pts_dropped = 0;
    endfunction

    // Accumulate one point; on a closing point return the solved fit.
    function automatic bit add_point(in_t p, output out_t fit);
        longint x;
        longint y;
        wide_t  det;
        x = p.x_value;
        y = p.y_value;
        fit = '0;
        if (n_pts < MAX_POINTS)
        begin
            n_pts++;
            s_x   += x;
            s_x2  += x*x;
            s_x3  += x*x*x;
            s_x4  += x*x*x*x;
            s_y   += y;
            s_xy  += x*y;
            s_x2y += x*x*y;
        end
        else
            pts_dropped = 1;
        if (!p.last_point)
            return 0;
        det = det3(s_x4, s_x3, s_x2, s_x3, s_x2, s_x, s_x2, s_x, n_pts);
        if (pts_dropped)
            fit.fit_status = ST_OVERFLOW;
        else if (det == 0)
            fit.fit_status = ST_SINGULAR;
        else
        begin
            fit.fit_status  = ST_OK;
            fit.coeff_quad  = q32_div(det3(s_x2y, s_x3, s_x2, s_xy, s_x2, s_x,
                                           s_y, s_x, n_pts), det);
            fit.coeff_lin   = q32_div(det3(s_x4, s_x2y, s_x2, s_x3, s_xy, s_x,
                                           s_x2, s_y, n_pts), det);
            fit.coeff_const = q32_div(det3(s_x4, s_x3, s_x2y, s_x3, s_x2, s_xy,
                                           s_x2, s_x, s_y), det);
        end
        clear_sums();
        return 1;
    endfunction

    task automatic send_point(in_t p, bit typed = 0, out_t typed_fit = '0);
        out_t fit;
        int   gap;
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
        if (add_point(p, fit))
            fit_q.push_back(typed ? typed_fit : fit);
        @(negedge clk);
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic row_t mk(int x, int y, bit last, bit typed = 0,
                                logic [STAT_W-1:0] st = ST_OK,
                                logic [63:0] a = 0, logic [63:0] b = 0,
                                logic [63:0] c = 0);
        row_t r;
        r.pt.x_value     = X_W'(x);
        r.pt.y_value     = Y_W'(y);
        r.pt.last_point  = last;
        r.typed          = typed;
        r.fit.coeff_quad = a;
        r.fit.coeff_lin  = b;
        r.fit.coeff_const = c;
        r.fit.fit_status = st;
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_t want;
        if (out_valid && out_ready)
        begin
            if (fit_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = fit_q.pop_front();
                if (out_data.coeff_quad !== want.coeff_quad)
                begin
                    $display("%0t: coeff_quad expected %h actual %h", $time,
                             want.coeff_quad, out_data.coeff_quad);
                    errors++;
                end
                if (out_data.coeff_lin !== want.coeff_lin)
                begin
                    $display("%0t: coeff_lin expected %h actual %h", $time,
                             want.coeff_lin, out_data.coeff_lin);
                    errors++;
                end
                if (out_data.coeff_const !== want.coeff_const)
                begin
                    $display("%0t: coeff_const expected %h actual %h", $time,
                             want.coeff_const, out_data.coeff_const);
                    errors++;
                end
                if (out_data.fit_status !== want.fit_status)
                begin
                    $display("%0t: fit_status expected %0d actual %0d", $time,
                             want.fit_status, out_data.fit_status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int mode;
        out_ready = 1'b0;
        @(posedge rst_n);
        while (!sending_done || fit_q.size() != 0)
        begin
            @(negedge clk);
            mode = $urandom_range(0, 9);
            if (mode < 5)
                out_ready <= 1'b1;
            else if (mode < 9)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge clk);
            end
        end
        @(negedge clk);
        out_ready <= 1'b1;
    end

    initial
    begin
        int   sent;
        int   len;
        int   span;
        int   xs;
        bit   drained;
        in_t  p;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        errors       = 0;
        sending_done = 0;
        drained      = 0;
        clear_sums();

        // single point, two points on one x, exact parabola, constant, extremes, four points on one x
        dir_rows.push_back(mk(5, 100, 1, 1, ST_SINGULAR));
        dir_rows.push_back(mk(3, 1, 0));
        dir_rows.push_back(mk(3, 2, 1, 1, ST_SINGULAR));
        dir_rows.push_back(mk(0, 0, 0));
        dir_rows.push_back(mk(1, 1, 0));
        dir_rows.push_back(mk(2, 4, 1, 1, ST_OK, 64'h1_0000_0000));
        dir_rows.push_back(mk(0, 7, 0));
        dir_rows.push_back(mk(1, 7, 0));
        dir_rows.push_back(mk(-1, 7, 1, 1, ST_OK, 0, 0, 64'h7_0000_0000));
        dir_rows.push_back(mk(-2048, -32768, 0));
        dir_rows.push_back(mk(2047, 32767, 0));
        dir_rows.push_back(mk(0, -32768, 0));
        dir_rows.push_back(mk(-2048, 32767, 0));
        dir_rows.push_back(mk(2047, -32768, 1));
        dir_rows.push_back(mk(0, 32767, 0));
        dir_rows.push_back(mk(1, -32768, 0));
        dir_rows.push_back(mk(2, 32767, 1));
        dir_rows.push_back(mk(-1, -1, 0));
        dir_rows.push_back(mk(-1, 5, 0));
        dir_rows.push_back(mk(-1, 9, 0));
        dir_rows.push_back(mk(-1, 0, 1, 1, ST_SINGULAR));
        dir_rows.push_back(mk(-2048, 1, 0));
        dir_rows.push_back(mk(2047, 2, 0));
        dir_rows.push_back(mk(-7, 3, 1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].fit);

        // past the point limit: dropped points, then overflow status
        for (int i = 0; i <= MAX_POINTS + 2; i++)
        begin
            p.x_value    = X_W'($urandom);
            p.y_value    = Y_W'($urandom);
            p.last_point = (i == MAX_POINTS + 2);
            send_point(p);
        end

        sent = 0;
        while (sent < 750)
        begin
            if (!drained && sent > 300)
            begin
                in_valid <= 1'b0;
                wait (fit_q.size() == 0);
                @(negedge clk);
                drained = 1;
            end
            mode_pick: begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) :
                       ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                       $urandom_range(3, 12);
                span = $urandom_range(0, 3);
            end
            for (int i = 0; i < len; i++)
            begin
                case (span)
                    0: xs = $urandom_range(0, 4) - 2;
                    1: xs = $urandom_range(0, 64) - 32;
                    default: xs = $signed(12'($urandom));
                endcase
                p.x_value    = X_W'(xs);
                p.y_value    = ($urandom_range(0, 1) == 0) ? Y_W'($urandom) :
                               Y_W'(xs * xs - 3 * xs + $urandom_range(0, 4));
                p.last_point = (i == len - 1);
                send_point(p);
                sent++;
            end
        end
        sending_done = 1;
        in_valid <= 1'b0;
        wait (fit_q.size() == 0);
        repeat (4000) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
